>>> hdl/pps_pkg.sv
package pps_pkg;

    localparam int MaxPacket = 8;
    localparam int LenW      = 4;
    localparam int IdxW      = $clog2(MaxPacket);
    localparam int TimerW    = 10;
    localparam int OpW       = 3;
    localparam int DataW     = 32;
    localparam int AddrW     = 1;

    localparam logic [TimerW-1:0] AckTimeoutReset = TimerW'(12);
    localparam logic [AddrW-1:0]  RegAckTimeout   = AddrW'(0);

    typedef enum logic [OpW-1:0] {
        OP_LOAD  = 3'd0,
        OP_START = 3'd1,
        OP_ACK   = 3'd2,
        OP_RX    = 3'd3,
        OP_TICK  = 3'd4
    } t_op;

    typedef struct packed {
        logic [OpW-1:0]  operation;
        logic [2:0]      req_index;
        logic [7:0]      req_byte;
        logic [7:0]      addr_byte;
        logic            port_select;
        logic [LenW-1:0] req_length;
        logic [LenW-1:0] max_resp_length;
        logic [7:0]      rx_byte;
    } t_item;

    typedef struct packed {
        logic            send_valid;
        logic [7:0]      send_byte;
        logic            select_active;
        logic            port_out;
        logic            resp_valid;
        logic [7:0]      resp_byte;
        logic [2:0]      resp_index;
        logic            done_res;
        logic [LenW-1:0] resp_count;
        logic            busy_res;
    } t_result;

    function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] len);
        logic [LenW-1:0] lim;
        lim = LenW'(MaxPacket);
        return (len > lim) ? lim : len;
    endfunction

endpackage

>>> hdl/pps_cfg.sv
module pps_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pps_pkg::AddrW-1:0]   paddr,
    input  logic [pps_pkg::DataW-1:0]   pwdata,
    output logic [pps_pkg::DataW-1:0]   prdata,
    output logic                        pready,
    output logic [pps_pkg::TimerW-1:0]  o_ack_timeout
);
    import pps_pkg::*;

    logic [TimerW-1:0] r_ack_timeout;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= AckTimeoutReset;
        end else if (wr_en && (paddr == RegAckTimeout)) begin
            r_ack_timeout <= pwdata[TimerW-1:0];
        end
    end

    always_comb begin
        unique case (paddr)
            RegAckTimeout: prdata = {{(DataW-TimerW){1'b0}}, r_ack_timeout};
            default:       prdata = '0;
        endcase
    end

    assign o_ack_timeout = r_ack_timeout;

endmodule

>>> hdl/pps_ctrl.sv
module pps_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  pps_pkg::t_item              i_item,
    input  logic [pps_pkg::TimerW-1:0]  i_ack_timeout,
    output pps_pkg::t_result            o_result
);
    import pps_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ADDR_ACK,
        PH_WAIT_RX,
        PH_WAIT_ACK
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [TimerW-1:0] r_ack_timer, n_ack_timer;
    logic              r_ack_pending, n_ack_pending;
    logic [LenW-1:0]   r_sent_count, n_sent_count;
    logic [LenW-1:0]   r_recv_count, n_recv_count;
    logic [LenW-1:0]   r_req_len, n_req_len;
    logic [LenW-1:0]   r_max_len, n_max_len;
    logic              r_port, n_port;
    logic [7:0]        r_store [MaxPacket];

    logic [TimerW-1:0] limit;
    logic [TimerW-1:0] timer_inc;
    logic [7:0]        tx_byte;
    logic              do_advance;
    t_result           res;

    assign limit     = (i_ack_timeout == '0) ? TimerW'(1) : i_ack_timeout;
    assign timer_inc = r_ack_timer + TimerW'(1);
    assign tx_byte   = (r_sent_count < r_req_len) ? r_store[r_sent_count[IdxW-1:0]] : 8'h00;

    always_comb begin
        n_phase       = r_phase;
        n_ack_timer   = r_ack_timer;
        n_ack_pending = r_ack_pending;
        n_sent_count  = r_sent_count;
        n_recv_count  = r_recv_count;
        n_req_len     = r_req_len;
        n_max_len     = r_max_len;
        n_port        = r_port;
        do_advance    = 1'b0;
        res           = '0;

        case (i_item.operation)
            OP_START: begin
                if (r_phase == PH_IDLE) begin
                    n_port        = i_item.port_select;
                    n_req_len     = clamp_len(i_item.req_length);
                    n_max_len     = clamp_len(i_item.max_resp_length);
                    n_sent_count  = '0;
                    n_recv_count  = '0;
                    n_ack_timer   = '0;
                    n_ack_pending = 1'b0;
                    n_phase       = PH_ADDR_ACK;
                    res.send_valid = 1'b1;
                    res.send_byte  = i_item.addr_byte;
                end
            end
            OP_ACK: begin
                if (r_phase == PH_ADDR_ACK || r_phase == PH_WAIT_ACK) begin
                    n_ack_timer = '0;
                    do_advance  = 1'b1;
                end else if (r_phase == PH_WAIT_RX) begin
                    n_ack_pending = 1'b1;
                end
            end
            OP_RX: begin
                if (r_phase == PH_WAIT_RX) begin
                    res.resp_valid = 1'b1;
                    res.resp_byte  = i_item.rx_byte;
                    res.resp_index = r_recv_count[2:0];
                    n_recv_count   = r_recv_count + LenW'(1);
                    n_ack_timer    = '0;
                    if (r_ack_pending) begin
                        n_ack_pending = 1'b0;
                        do_advance    = 1'b1;
                    end else begin
                        n_phase = PH_WAIT_ACK;
                    end
                end
            end
            OP_TICK: begin
                if (r_phase == PH_ADDR_ACK || r_phase == PH_WAIT_ACK) begin
                    n_ack_timer = timer_inc;
                    if (timer_inc == '0 || timer_inc >= limit) begin
                        n_ack_timer    = '0;
                        n_phase        = PH_IDLE;
                        res.done_res   = 1'b1;
                        res.resp_count = r_recv_count;
                    end
                end
            end
            default: begin
            end
        endcase

        if (do_advance) begin
            if (n_recv_count >= r_max_len) begin
                n_phase        = PH_IDLE;
                res.done_res   = 1'b1;
                res.resp_count = n_recv_count;
            end else begin
                res.send_valid = 1'b1;
                res.send_byte  = tx_byte;
                n_sent_count   = r_sent_count + LenW'(1);
                n_ack_pending  = 1'b0;
                n_phase        = PH_WAIT_RX;
            end
        end

        res.select_active = (n_phase != PH_IDLE);
        res.port_out      = n_port;
        res.busy_res      = res.select_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_ack_timer   <= '0;
            r_ack_pending <= 1'b0;
            r_sent_count  <= '0;
            r_recv_count  <= '0;
            r_req_len     <= '0;
            r_max_len     <= '0;
            r_port        <= 1'b0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_ack_timer   <= n_ack_timer;
            r_ack_pending <= n_ack_pending;
            r_sent_count  <= n_sent_count;
            r_recv_count  <= n_recv_count;
            r_req_len     <= n_req_len;
            r_max_len     <= n_max_len;
            r_port        <= n_port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && (i_item.operation == OP_LOAD)) begin
            r_store[i_item.req_index[IdxW-1:0]] <= i_item.req_byte;
        end
    end

    assign o_result = res;

endmodule

>>> hdl/pad_port_packet_sequencer.sv
// Master-side sequencer for a controller-port packet exchange.
// Input channel (i_in_valid / o_in_stall): each transaction is one event:
// load a request byte, start a packet, acknowledge pulse, received byte, or
// a ten-microsecond tick. Output channel (o_out_valid / i_out_stall): every
// input transaction produces exactly one result transaction carrying the byte
// to send, select and port state, a reply byte with its index, and the done
// flag with the reply count.
// An accepted transaction is held in an input register and evaluated against
// the sequencer state once the output register is free; its result is then
// registered in the output register. One transaction per cycle is sustained
// when the receiver does not stall.
// When the receiver stalls, the pending result holds its value, the input
// register keeps one more transaction, and o_in_stall rises once both are full.
// The user must write the acknowledge timeout register over the APB port only
// while the block is idle; this is not enforced. Reset idles the sequencer,
// sets the timeout to twelve ticks; request bytes must be loaded before use.
module pad_port_packet_sequencer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_operation,
    input  logic [2:0]                  i_req_index,
    input  logic [7:0]                  i_req_byte,
    input  logic [7:0]                  i_addr_byte,
    input  logic                        i_port_select,
    input  logic [3:0]                  i_req_length,
    input  logic [3:0]                  i_max_resp_length,
    input  logic [7:0]                  i_rx_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_send_valid,
    output logic [7:0]                  o_send_byte,
    output logic                        o_select_active,
    output logic                        o_port_out,
    output logic                        o_resp_valid,
    output logic [7:0]                  o_resp_byte,
    output logic [2:0]                  o_resp_index,
    output logic                        o_done_res,
    output logic [3:0]                  o_resp_count,
    output logic                        o_busy_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pps_pkg::AddrW-1:0]   paddr,
    input  logic [pps_pkg::DataW-1:0]   pwdata,
    output logic [pps_pkg::DataW-1:0]   prdata,
    output logic                        pready
);
    import pps_pkg::*;

    logic              r_in_valid;
    t_item             r_item;
    logic              r_out_valid;
    t_result           r_result;
    logic              out_free;
    logic              fire;
    logic              in_take;
    logic [TimerW-1:0] ack_timeout;
    t_result           result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.operation       <= i_operation;
            r_item.req_index       <= i_req_index;
            r_item.req_byte        <= i_req_byte;
            r_item.addr_byte       <= i_addr_byte;
            r_item.port_select     <= i_port_select;
            r_item.req_length      <= i_req_length;
            r_item.max_resp_length <= i_max_resp_length;
            r_item.rx_byte         <= i_rx_byte;
        end
    end

    pps_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_ack_timeout (ack_timeout)
    );

    pps_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_item        (r_item),
        .i_ack_timeout (ack_timeout),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_send_valid    = r_result.send_valid;
    assign o_send_byte     = r_result.send_byte;
    assign o_select_active = r_result.select_active;
    assign o_port_out      = r_result.port_out;
    assign o_resp_valid    = r_result.resp_valid;
    assign o_resp_byte     = r_result.resp_byte;
    assign o_resp_index    = r_result.resp_index;
    assign o_done_res      = r_result.done_res;
    assign o_resp_count    = r_result.resp_count;
    assign o_busy_res      = r_result.busy_res;

endmodule
